>>> design/vlsp_pkg.sv
// ----------------------------------------------------------------------------
// vlsp_pkg: shared types and codes of the varint length string parser
// Item formats, result kinds, error codes and the parser phase type.
// ----------------------------------------------------------------------------
package vlsp_pkg;

    localparam int VLSP_QUEUE_DEPTH = 2;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [1:0] ERR_TOO_LONG  = 2'd0;
    localparam logic [1:0] ERR_OVER_MAX  = 2'd1;
    localparam logic [1:0] ERR_NEGATIVE  = 2'd2;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd3;

    // Number of length bytes allowed by the format.
    localparam logic [2:0] MAX_LEN_BYTES = 3'd5;

    typedef enum logic {
        PHASE_LENGTH  = 1'b0,
        PHASE_PAYLOAD = 1'b1
    } t_vlsp_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_data;
    } t_vlsp_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic        last_of_string;
        logic [30:0] string_length;
        logic [1:0]  error_code;
    } t_vlsp_out;

    // One queue entry: a result item, optionally followed by an underflow error.
    typedef struct packed {
        t_vlsp_out item;
        logic      tail_err;
    } t_vlsp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_vlsp_qstat;

endpackage

>>> design/vlsp_front.sv
// ----------------------------------------------------------------------------
// vlsp_front: byte classifier
// Decodes the base-128 length prefix, counts payload bytes and turns each
// accepted byte into at most one queue entry.
// ----------------------------------------------------------------------------
module vlsp_front
    import vlsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_vlsp_in    i_in_data,
    output logic        o_in_stall,
    input  logic        i_cfg_valid,
    input  logic [30:0] i_cfg_data,
    output logic        o_cfg_ready,
    input  t_vlsp_qstat i_qstat,
    output logic        o_push,
    output t_vlsp_cmd   o_cmd
);

    t_vlsp_phase r_phase, n_phase;
    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_cnt, n_cnt;
    logic [30:0] r_left, n_left;
    logic [30:0] r_max_length;

    logic        w_accept;
    logic [31:0] w_seven;
    logic [31:0] w_add;
    logic [31:0] w_acc_new;
    logic [2:0]  w_cnt_new;
    logic        w_fail;
    logic [1:0]  w_fail_code;
    logic        w_empty;
    logic        w_start;
    logic        w_more;
    logic        w_last;
    logic        w_tail_err;

    assign o_in_stall  = i_qstat.full;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !i_qstat.full;

    // Place the seven data bits at bit 7*i; the fifth byte keeps only four.
    always_comb begin
        w_seven = {25'd0, i_in_data.in_byte[6:0]};
        case (r_cnt)
            3'd0:    w_add = w_seven;
            3'd1:    w_add = w_seven << 7;
            3'd2:    w_add = w_seven << 14;
            3'd3:    w_add = w_seven << 21;
            3'd4:    w_add = w_seven << 28;
            default: w_add = '0;
        endcase
        w_acc_new = r_acc | w_add;
        w_cnt_new = r_cnt + 3'd1;
    end

    // Classification of the current byte.
    always_comb begin
        w_fail      = 1'b0;
        w_fail_code = ERR_TOO_LONG;
        w_empty     = 1'b0;
        w_start     = 1'b0;
        w_more      = 1'b0;
        w_last      = (r_left <= 31'd1);
        w_tail_err  = 1'b0;
        if (r_phase == PHASE_LENGTH) begin
            if (i_in_data.in_byte[7]) begin
                if (w_cnt_new >= MAX_LEN_BYTES) begin
                    w_fail      = 1'b1;
                    w_fail_code = ERR_TOO_LONG;
                end else if (i_in_data.end_of_data) begin
                    w_fail      = 1'b1;
                    w_fail_code = ERR_UNDERFLOW;
                end else begin
                    w_more = 1'b1;
                end
            end else if (w_acc_new[31]) begin
                w_fail      = 1'b1;
                w_fail_code = ERR_NEGATIVE;
            end else if (r_max_length != '0 && w_acc_new[30:0] > r_max_length) begin
                w_fail      = 1'b1;
                w_fail_code = ERR_OVER_MAX;
            end else if (w_acc_new == '0) begin
                w_empty = 1'b1;
            end else if (i_in_data.end_of_data) begin
                w_fail      = 1'b1;
                w_fail_code = ERR_UNDERFLOW;
            end else begin
                w_start = 1'b1;
            end
        end else begin
            w_tail_err = !w_last && i_in_data.end_of_data;
        end
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (w_accept) begin
            case (r_phase)
                PHASE_LENGTH: begin
                    if (w_start) begin
                        n_phase = PHASE_PAYLOAD;
                    end
                end
                PHASE_PAYLOAD: begin
                    if (w_last || i_in_data.end_of_data) begin
                        n_phase = PHASE_LENGTH;
                    end
                end
                default: n_phase = PHASE_LENGTH;
            endcase
        end
    end

    // Queue entry and datapath registers.
    always_comb begin
        o_push = 1'b0;
        o_cmd  = '0;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_left = r_left;
        if (w_accept) begin
            if (r_phase == PHASE_LENGTH) begin
                if (w_more) begin
                    n_acc = w_acc_new;
                    n_cnt = w_cnt_new;
                end else if (w_start) begin
                    n_acc  = w_acc_new;
                    n_cnt  = '0;
                    n_left = w_acc_new[30:0];
                end else if (w_fail || w_empty) begin
                    o_push = 1'b1;
                    n_acc  = '0;
                    n_cnt  = '0;
                    n_left = '0;
                    if (w_empty) begin
                        o_cmd.item.kind           = KIND_EMPTY;
                        o_cmd.item.last_of_string = 1'b1;
                    end else begin
                        o_cmd.item.kind          = KIND_ERROR;
                        o_cmd.item.string_length = w_acc_new[30:0];
                        o_cmd.item.error_code    = w_fail_code;
                    end
                end
            end else begin
                o_push                    = 1'b1;
                o_cmd.item.kind           = KIND_PAYLOAD;
                o_cmd.item.out_byte       = i_in_data.in_byte;
                o_cmd.item.last_of_string = w_last;
                o_cmd.item.string_length  = r_acc[30:0];
                o_cmd.tail_err            = w_tail_err;
                if (w_last || i_in_data.end_of_data) begin
                    n_acc  = '0;
                    n_cnt  = '0;
                    n_left = '0;
                end else begin
                    n_left = r_left - 31'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PHASE_LENGTH;
            r_acc        <= '0;
            r_cnt        <= '0;
            r_left       <= '0;
            r_max_length <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_left  <= n_left;
            if (i_cfg_valid) begin
                r_max_length <= i_cfg_data;
            end
        end
    end

endmodule

>>> design/vlsp_queue.sv
// ----------------------------------------------------------------------------
// vlsp_queue: command queue between classifier and result stage
// A small circular buffer of queue entries with full and empty status.
// ----------------------------------------------------------------------------
module vlsp_queue
    import vlsp_pkg::*;
#(
    parameter int DEPTH = VLSP_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_vlsp_cmd   i_cmd,
    input  logic        i_pop,
    output t_vlsp_cmd   o_cmd,
    output t_vlsp_qstat o_qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_vlsp_cmd          r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               w_push;
    logic               w_pop;

    assign o_qstat.full  = (r_count == CNT_W'(DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign w_push        = i_push && !o_qstat.full;
    assign w_pop         = i_pop && !o_qstat.empty;
    assign o_cmd         = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> design/vlsp_back.sv
// ----------------------------------------------------------------------------
// vlsp_back: result stage
// Drains queue entries into the output register and appends the underflow
// error item where an entry asks for one.
// ----------------------------------------------------------------------------
module vlsp_back
    import vlsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_vlsp_cmd   i_cmd,
    input  t_vlsp_qstat i_qstat,
    output logic        o_pop,
    output logic        o_out_valid,
    output t_vlsp_out   o_out_data,
    input  logic        i_out_stall
);

    logic      r_out_valid, n_out_valid;
    t_vlsp_out r_out_data, n_out_data;
    logic      r_err_pending, n_err_pending;
    logic      w_free;

    assign w_free      = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        o_pop         = 1'b0;
        n_out_valid   = r_out_valid;
        n_out_data    = r_out_data;
        n_err_pending = r_err_pending;
        if (w_free) begin
            if (r_err_pending) begin
                // The payload item now leaving still holds the string length.
                n_out_valid               = 1'b1;
                n_out_data.kind           = KIND_ERROR;
                n_out_data.out_byte       = '0;
                n_out_data.last_of_string = 1'b0;
                n_out_data.error_code     = ERR_UNDERFLOW;
                n_err_pending             = 1'b0;
            end else if (!i_qstat.empty) begin
                o_pop         = 1'b1;
                n_out_valid   = 1'b1;
                n_out_data    = i_cmd.item;
                n_err_pending = i_cmd.tail_err;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_err_pending <= 1'b0;
        end else begin
            r_out_valid   <= n_out_valid;
            r_err_pending <= n_err_pending;
        end
    end

endmodule

>>> design/varint_length_string_parser.sv
// Path: a taken byte is written into the queue, and its result is then registered in the output register.
// Throughput: one byte per cycle while the queue is not full; a byte whose string is cut
// short by end of data yields two items, so the queue can fill and the input can stall.
// Reset: i_rst_n is synchronous and active low; it returns the parser to reading a length,
// empties the queue and the output register and sets max_length to zero.
// ----------------------------------------------------------------------------
// varint_length_string_parser: length-prefixed string parser
// Reads a base-128 length prefix of up to five bytes, then passes that many
// payload bytes through, reporting empty strings and format errors.
// ----------------------------------------------------------------------------
module varint_length_string_parser
    import vlsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = VLSP_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_vlsp_in    i_in_data,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_vlsp_out   o_out_data,
    input  logic        i_out_stall,
    input  logic        i_cfg_valid,
    input  logic [30:0] i_cfg_data,
    output logic        o_cfg_ready
);

    logic        w_push;
    logic        w_pop;
    t_vlsp_cmd   w_push_cmd;
    t_vlsp_cmd   w_head_cmd;
    t_vlsp_qstat w_qstat;

    vlsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_qstat     (w_qstat),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    vlsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_qstat (w_qstat)
    );

    vlsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_head_cmd),
        .i_qstat     (w_qstat),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

`ifndef SYNTHESIS
    a_queue_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_qstat.full && w_qstat.empty))
        else $error("queue reports full and empty together");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind == KIND_ERROR) |->
        (!o_out_data.last_of_string && o_out_data.out_byte == '0))
        else $error("error item carries payload fields");

    a_empty_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind == KIND_EMPTY) |->
        (o_out_data.last_of_string && o_out_data.string_length == '0))
        else $error("empty-string item malformed");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.full |-> !w_push)
        else $error("item classified while queue full");
`endif

endmodule
